FILE: design/bec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bec_pkg
// shared types, constants and code tables for the byte ecc (16,8) codec
// ----------------------------------------------------------------------------
package bec_pkg;

  localparam int DEC_DEPTH = 256;
  localparam int NUM_COLS  = 16;

  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_CHECK  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAN = 2'd0,
    ST_ONE   = 2'd1,
    ST_TWO   = 2'd2,
    ST_FAIL  = 2'd3
  } status_t;

  // generator rows, row 0 gives the msb of the check byte
  localparam logic [7:0] GEN_ROWS [8] = '{
    8'h2B, 8'h95, 8'hCA, 8'h65, 8'hB2, 8'h59, 8'hAC, 8'h56
  };

  // data columns of the parity check matrix (generator transposed)
  localparam logic [7:0] DATA_COLS [8] = '{
    8'h6A, 8'h35, 8'h9A, 8'h4D, 8'hA6, 8'h53, 8'hA9, 8'hD4
  };

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic [7:0] check_byte;
    logic       last_byte;
  } bec_in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic [7:0] check_out;
    logic [1:0] status;
    logic       last_out;
  } bec_out_t;

  // syndrome stage to locate stage
  typedef struct packed {
    logic       action;
    logic [7:0] data;
    logic [7:0] chk;   // computed check on encode, stored check on check
    logic [7:0] syn;
    logic       last;
  } bec_s1_t;

  // locate stage to correct stage
  typedef struct packed {
    logic [7:0]  data;
    logic [7:0]  chk;
    logic [15:0] mask;
    status_t     status;
    logic        last;
  } bec_s2_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] mask;
  } dec_ent_t;

  typedef dec_ent_t [DEC_DEPTH-1:0] dec_tbl_t;

  function automatic logic [7:0] make_check(input logic [7:0] data);
    logic [7:0] chk;
    chk = '0;
    for (int i = 0; i < 8; i++) begin
      chk[7-i] = ^(data & GEN_ROWS[i]);
    end
    return chk;
  endfunction

  // column c belongs to codeword bit 15-c
  function automatic logic [7:0] column(input int c);
    logic [7:0] col;
    if (c < 8) begin
      col = DATA_COLS[c];
    end else begin
      col = 8'(1 << (15 - c));
    end
    return col;
  endfunction

  // syndrome to flip mask and status, built at elaboration
  function automatic dec_tbl_t build_dec_tbl();
    dec_tbl_t   tbl;
    logic [7:0] s;
    logic       found;
    for (int sv = 0; sv < DEC_DEPTH; sv++) begin
      s = 8'(sv);
      found = 1'b0;
      tbl[sv].status = ST_CLEAN;
      tbl[sv].mask   = '0;
      if (s != 8'h00) begin
        for (int a = 0; a < NUM_COLS; a++) begin
          if (!found && column(a) == s) begin
            tbl[sv].mask[15-a] = 1'b1;
            tbl[sv].status     = ST_ONE;
            found              = 1'b1;
          end
        end
        for (int a = 0; a < NUM_COLS; a++) begin
          for (int b = a + 1; b < NUM_COLS; b++) begin
            if (!found && (column(a) ^ column(b)) == s) begin
              tbl[sv].mask[15-a] = 1'b1;
              tbl[sv].mask[15-b] = 1'b1;
              tbl[sv].status     = ST_TWO;
              found              = 1'b1;
            end
          end
        end
        if (!found) begin
          tbl[sv].status = ST_FAIL;
        end
      end
    end
    return tbl;
  endfunction

  localparam dec_tbl_t DEC_TBL = build_dec_tbl();

endpackage

FILE: design/byte_ecc_16_8_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ecc_16_8_codec
// per-byte (16,8) linear block code: encode, or check with up to two-bit repair
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    bec_in_t  (action, data, check, last)
//   out_     output     out_valid/out_ready  bec_out_t (data, check, status, last)
//
// three register stages (syndrome, table lookup, correction) lie between an
// accepted input beat and its result beat; one beat per cycle sustained while
// out_ready stays high; each stage holds its beat while the next one is full
// and stalled, and takes a new one as soon as it frees up
// synchronous active-low reset clears only the stage valid bits
// ----------------------------------------------------------------------------
module byte_ecc_16_8_codec (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bec_pkg::bec_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bec_pkg::bec_out_t out_data
);

  // stage 1 to stage 2
  logic             s1_valid;
  logic             s1_ready;
  bec_pkg::bec_s1_t s1_data;

  // stage 2 to stage 3
  logic             s2_valid;
  logic             s2_ready;
  bec_pkg::bec_s2_t s2_data;

  // parity of data against each generator row, xor with stored check byte
  bec_syndrome u_syndrome (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  // constant 256-entry syndrome table: first single column, then first pair
  bec_locate u_locate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  // flip the located bits; this stage is the output register
  bec_correct u_correct (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: design/bec_syndrome.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bec_syndrome
// first stage: check byte from the data byte and the syndrome
// ----------------------------------------------------------------------------
module bec_syndrome (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bec_pkg::bec_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bec_pkg::bec_s1_t out_data
);

  logic             valid_r;
  bec_pkg::bec_s1_t stage_r;
  bec_pkg::bec_s1_t stage_nxt;
  logic [7:0]       calc;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    calc             = bec_pkg::make_check(in_data.data_byte);
    stage_nxt.action = in_data.action;
    stage_nxt.data   = in_data.data_byte;
    stage_nxt.chk    = (in_data.action == bec_pkg::ACT_CHECK) ? in_data.check_byte : calc;
    stage_nxt.syn    = in_data.check_byte ^ calc;
    stage_nxt.last   = in_data.last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = stage_r;

endmodule

FILE: design/bec_locate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bec_locate
// second stage: syndrome table lookup giving the flip mask and status on check,
// clean status and no flips on encode
module bec_locate (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bec_pkg::bec_s1_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bec_pkg::bec_s2_t out_data
);

  logic              valid_r;
  bec_pkg::bec_s2_t  stage_r;
  bec_pkg::bec_s2_t  stage_nxt;
  bec_pkg::dec_ent_t ent;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    ent            = bec_pkg::DEC_TBL[in_data.syn];
    stage_nxt.data = in_data.data;
    stage_nxt.chk  = in_data.chk;
    stage_nxt.last = in_data.last;
    if (in_data.action == bec_pkg::ACT_CHECK) begin
      stage_nxt.mask   = ent.mask;
      stage_nxt.status = ent.status;
    end else begin
      stage_nxt.mask   = '0;
      stage_nxt.status = bec_pkg::ST_CLEAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = stage_r;

  // flip count agrees with the reported status
  a_one_flip: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && stage_r.status == bec_pkg::ST_ONE |-> $countones(stage_r.mask) == 1)
    else $error("single correction without exactly one flipped bit");

  a_two_flip: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && stage_r.status == bec_pkg::ST_TWO |-> $countones(stage_r.mask) == 2)
    else $error("double correction without exactly two flipped bits");

  a_no_flip: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (stage_r.status == bec_pkg::ST_CLEAN || stage_r.status == bec_pkg::ST_FAIL)
    |-> stage_r.mask == 16'h0000)
    else $error("clean or uncorrectable byte with a nonzero flip mask");

endmodule

FILE: design/bec_correct.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bec_correct
// last stage: applies the flip mask and holds the result beat
// ----------------------------------------------------------------------------
module bec_correct (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bec_pkg::bec_s2_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bec_pkg::bec_out_t out_data
);

  logic              valid_r;
  bec_pkg::bec_out_t res_r;
  bec_pkg::bec_out_t res_nxt;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    res_nxt.data_out  = in_data.data ^ in_data.mask[15:8];
    res_nxt.check_out = in_data.chk ^ in_data.mask[7:0];
    res_nxt.status    = in_data.status;
    res_nxt.last_out  = in_data.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = res_r;

endmodule
